### rtl/vtcv_pkg.sv
// Package for the vertex transform, clip and viewport unit.
// Holds field widths, register addresses, sequencer states and saturation helpers.
// No dependencies.
`default_nettype none

package vtcv_pkg;

	// Default design constants.
	localparam int FRAC_BITS_DEF    = 16;
	localparam int NUM_MATRICES_DEF = 3;

	// Payload field widths.
	localparam int COEF_IDX_W = 6;
	localparam int WORD_W     = 32;
	localparam int SCREEN_W   = 16;

	// Wide working width for products and sums.
	localparam int WIDE_W = 66;

	// Divider widths: the denominator is a positive w or 2w; the numerator
	// is hx*(x+w) or (z+w) shifted up by the fraction bits.
	localparam int DIV_DEN_W = 33;
	localparam int DIV_NUM_W_DEF = 49;

	// Configuration register indexes.
	localparam logic [2:0] REG_VP_WIDTH  = 3'd0;
	localparam logic [2:0] REG_VP_HEIGHT = 3'd1;
	localparam logic [2:0] REG_OFFSET_X  = 3'd2;
	localparam logic [2:0] REG_OFFSET_Y  = 3'd3;
	localparam logic [2:0] REG_NEAR      = 3'd4;
	localparam logic [2:0] REG_FAR       = 3'd5;
	localparam logic [2:0] REG_USE_WORLD = 3'd6;

	// Input command codes.
	localparam logic CMD_LOAD      = 1'b0;
	localparam logic CMD_TRANSFORM = 1'b1;

	// Sequencer states.
	typedef enum logic [4:0] {
		ST_IDLE,
		ST_MAC_RD,
		ST_MAC_MUL,
		ST_MAC_ACC,
		ST_COL_END,
		ST_CLIP,
		ST_SX_MUL,
		ST_SX_DIVS,
		ST_SX_DIVW,
		ST_SY_MUL,
		ST_SY_DIVS,
		ST_SY_DIVW,
		ST_T_DIVS,
		ST_T_DIVW,
		ST_DEP_MUL,
		ST_DEP_ADD,
		ST_OUT
	} vtcv_state_t;

	// Saturate a wide signed value to 32 bits.
	function automatic logic signed [WORD_W-1:0] sat32(input logic signed [WIDE_W-1:0] v);
		logic signed [WIDE_W-1:0] hi;
		logic signed [WIDE_W-1:0] lo;
		hi = WIDE_W'(signed'(33'sh0_7FFF_FFFF));
		lo = -hi - WIDE_W'(1);
		if (v > hi) begin
			return 32'sh7FFF_FFFF;
		end else if (v < lo) begin
			return 32'sh8000_0000;
		end else begin
			return v[WORD_W-1:0];
		end
	endfunction

	// Saturate an 18-bit signed value to 16 bits.
	function automatic logic signed [SCREEN_W-1:0] sat16(input logic signed [17:0] v);
		if (v > 18'sd32767) begin
			return 16'sh7FFF;
		end else if (v < -18'sd32768) begin
			return 16'sh8000;
		end else begin
			return v[SCREEN_W-1:0];
		end
	endfunction

endpackage

`default_nettype wire

### rtl/vtcv_if.sv
// Channel interfaces for the vertex transform unit: input words and result words.
// Depends on vtcv_pkg for field widths.
`default_nettype none

interface vtcv_in_if import vtcv_pkg::*; ();
	logic                     valid;
	logic                     ready;
	logic                     cmd;
	logic [COEF_IDX_W-1:0]    coef_index;
	logic signed [WORD_W-1:0] coef_value;
	logic signed [WORD_W-1:0] point_x;
	logic signed [WORD_W-1:0] point_y;
	logic signed [WORD_W-1:0] point_z;

	modport source (output valid, cmd, coef_index, coef_value, point_x, point_y, point_z,
		input ready);
	modport sink (input valid, cmd, coef_index, coef_value, point_x, point_y, point_z,
		output ready);
endinterface

interface vtcv_out_if import vtcv_pkg::*; ();
	logic                       valid;
	logic                       ready;
	logic                       visible;
	logic signed [SCREEN_W-1:0] screen_x;
	logic signed [SCREEN_W-1:0] screen_y;
	logic signed [WORD_W-1:0]   depth;

	modport source (output valid, visible, screen_x, screen_y, depth, input ready);
	modport sink (input valid, visible, screen_x, screen_y, depth, output ready);
endinterface

`default_nettype wire

### rtl/vertex_transform_clip_viewport_unit.sv
// Vertex transform, clip test and viewport mapping unit, top level.
// Depends on vtcv_pkg, vtcv_if (channel interfaces) and vtcv_div.
//
// Usage: words arrive on req. A load word (cmd 0) writes one matrix coefficient
// in the same cycle and gives no result. A transform word (cmd 1) runs the point
// through up to three 4x4 matrices, clips it and maps it to the screen; it gives
// exactly one result word on rsp. Registers are written over the APB port; the user must
// write them only while the unit is idle, as the block itself does not enforce it.
// Sequence: each matrix coefficient passes through read, multiply and accumulate on
// the one shared 33x33 multiplier, and each column ends in a column-end step. A
// visible point then runs three divisions on the shared DIV_NUM_W-bit divider (49 bits
// at the default format), for x, y and the depth fraction, and x and y each need one
// multiply first; depth then takes a multiply and an add. A clipped point goes from
// the clip test straight to the output. The unit returns to idle before it takes the
// next word, one transform at a time.
// A result waits in an output register; a stalled receiver holds the unit only
// when the next result is ready to go out. Reset returns the registers to their
// defaults and the sequencer to idle; coefficients are undefined until loaded.
`default_nettype none

module vertex_transform_clip_viewport_unit import vtcv_pkg::*; #(
	parameter int FRAC_BITS    = FRAC_BITS_DEF,
	parameter int NUM_MATRICES = NUM_MATRICES_DEF
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        psel,
	input  wire logic        penable,
	input  wire logic        pwrite,
	input  wire logic [4:0]  paddr,
	input  wire logic [31:0] pwdata,
	output logic [31:0]      prdata,
	output logic             pready,
	vtcv_in_if.sink          req,
	vtcv_out_if.source       rsp
);

	localparam int STORE_DEPTH = 16 * NUM_MATRICES;
	localparam int ADDR_W      = $clog2(STORE_DEPTH);
	localparam int MAT_W       = ADDR_W - 4;
	localparam int DIV_NUM_W   = (33 + FRAC_BITS > 49) ? 33 + FRAC_BITS : 49;

	// Configuration registers.
	logic [15:0]              vp_w_q;
	logic [15:0]              vp_h_q;
	logic signed [15:0]       off_x_q;
	logic signed [15:0]       off_y_q;
	logic signed [WORD_W-1:0] near_q;
	logic signed [WORD_W-1:0] far_q;
	logic                     use_world_q;
	logic                     cfg_wr;

	assign pready = 1'b1;
	assign cfg_wr = psel & penable & pwrite;

	// Register writes.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vp_w_q      <= 16'd640;
			vp_h_q      <= 16'd480;
			off_x_q     <= '0;
			off_y_q     <= '0;
			near_q      <= 32'sd65536;
			far_q       <= 32'sd6553600;
			use_world_q <= 1'b1;
		end else if (cfg_wr) begin
			case (paddr[4:2])
				REG_VP_WIDTH:  vp_w_q      <= pwdata[15:0];
				REG_VP_HEIGHT: vp_h_q      <= pwdata[15:0];
				REG_OFFSET_X:  off_x_q     <= pwdata[15:0];
				REG_OFFSET_Y:  off_y_q     <= pwdata[15:0];
				REG_NEAR:      near_q      <= pwdata;
				REG_FAR:       far_q       <= pwdata;
				REG_USE_WORLD: use_world_q <= pwdata[0];
				default: ;
			endcase
		end
	end

	// Register reads.
	always_comb begin
		case (paddr[4:2])
			REG_VP_WIDTH:  prdata = {16'd0, vp_w_q};
			REG_VP_HEIGHT: prdata = {16'd0, vp_h_q};
			REG_OFFSET_X:  prdata = 32'($signed(off_x_q));
			REG_OFFSET_Y:  prdata = 32'($signed(off_y_q));
			REG_NEAR:      prdata = near_q;
			REG_FAR:       prdata = far_q;
			REG_USE_WORLD: prdata = {31'd0, use_world_q};
			default:       prdata = '0;
		endcase
	end

	// Sequencer state and loop counters.
	vtcv_state_t state_q, state_d;
	logic [1:0]       r_q;
	logic [1:0]       c_q;
	logic [MAT_W-1:0] mat_q;
	logic [MAT_W-1:0] mat_first;
	logic             out_valid_q;
	logic             req_take;
	logic             div_start;
	logic             out_load;

	// Working vectors, accumulator and shared multiplier.
	logic signed [WORD_W-1:0] v_q [4];
	logic signed [WORD_W-1:0] o_q [4];
	logic signed [WIDE_W-1:0] acc_q;
	logic signed [WIDE_W-1:0] prod_q;
	logic signed [32:0]       mul_a;
	logic signed [32:0]       mul_b;
	logic signed [WIDE_W-1:0] mul_p;

	// Coefficient store.
	logic signed [WORD_W-1:0] coef_mem [STORE_DEPTH];
	logic signed [WORD_W-1:0] rd_q;
	logic [ADDR_W-1:0]        rd_addr;

	// Clip and mapping terms.
	logic signed [32:0] xw;
	logic signed [32:0] wy;
	logic signed [32:0] zw;
	logic signed [32:0] negw;
	logic signed [32:0] fmn;
	logic               vis_now;
	logic               vis_q;
	logic signed [SCREEN_W-1:0] sx_q;
	logic signed [SCREEN_W-1:0] sy_q;
	logic signed [WORD_W-1:0]   dep_q;
	logic [FRAC_BITS:0]         t_q;

	// Offset-corrected input point.
	logic signed [WIDE_W-1:0] in_x;
	logic signed [WIDE_W-1:0] in_y;

	// Divider hookup.
	logic [DIV_NUM_W-1:0] div_num;
	logic [DIV_DEN_W-1:0] div_den;
	logic                 div_busy;
	logic                 div_done;
	logic [DIV_NUM_W-1:0] div_quot;
	logic signed [17:0]   scr_sum;

	vtcv_div #(
		.NUM_W (DIV_NUM_W),
		.DEN_W (DIV_DEN_W)
	) u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (div_start),
		.num    (div_num),
		.den    (div_den),
		.busy   (div_busy),
		.done   (div_done),
		.quot   (div_quot)
	);

	assign mat_first = (NUM_MATRICES == 3 && !use_world_q) ? MAT_W'(1) : MAT_W'(0);
	assign rd_addr   = {mat_q, r_q, c_q};
	assign req_take  = req.valid && req.ready;

	always_comb begin
		in_x = WIDE_W'(req.point_x) - (WIDE_W'(off_x_q) <<< FRAC_BITS);
		in_y = WIDE_W'(req.point_y) - (WIDE_W'(off_y_q) <<< FRAC_BITS);
	end

	// Clip terms from the final stage result.
	always_comb begin
		xw   = 33'(o_q[0]) + 33'(o_q[3]);
		wy   = 33'(o_q[3]) - 33'(o_q[1]);
		zw   = 33'(o_q[2]) + 33'(o_q[3]);
		negw = -33'(o_q[3]);
		fmn  = 33'(far_q) - 33'(near_q);
		vis_now = (o_q[3] != '0)
			&& (negw <= 33'(o_q[2])) && (33'(o_q[2]) <= 33'(o_q[3]))
			&& (negw <= 33'(o_q[0])) && (33'(o_q[0]) <= 33'(o_q[3]))
			&& (negw < 33'(o_q[1])) && (33'(o_q[1]) <= 33'(o_q[3]));
	end

	// Shared multiplier operand selection.
	always_comb begin
		case (state_q)
			ST_MAC_MUL: begin
				mul_a = 33'(rd_q);
				mul_b = 33'(v_q[r_q]);
			end
			ST_SX_MUL: begin
				mul_a = 33'({1'b0, vp_w_q[15:1]});
				mul_b = xw;
			end
			ST_SY_MUL: begin
				mul_a = 33'({1'b0, vp_h_q[15:1]});
				mul_b = wy;
			end
			ST_DEP_MUL: begin
				mul_a = fmn;
				mul_b = 33'({1'b0, t_q});
			end
			default: begin
				mul_a = '0;
				mul_b = '0;
			end
		endcase
	end

	// Full-width signed product of the shared multiplier.
	assign mul_p = mul_a * mul_b;

	// Divider operand selection; w is positive whenever a division runs.
	always_comb begin
		if (state_q == ST_T_DIVS) begin
			div_num = DIV_NUM_W'($unsigned(zw)) << FRAC_BITS;
			div_den = {o_q[3], 1'b0};
		end else begin
			div_num = prod_q[DIV_NUM_W-1:0];
			div_den = DIV_DEN_W'($unsigned(o_q[3]));
		end
	end

	always_comb begin
		if (state_q == ST_SX_DIVW) begin
			scr_sum = 18'($signed({1'b0, div_quot[16:0]})) + 18'(off_x_q);
		end else begin
			scr_sum = 18'($signed({1'b0, div_quot[16:0]})) + 18'(off_y_q);
		end
	end

	// Next state.
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE:    if (req_take && req.cmd == CMD_TRANSFORM) state_d = ST_MAC_RD;
			ST_MAC_RD:  state_d = ST_MAC_MUL;
			ST_MAC_MUL: state_d = ST_MAC_ACC;
			ST_MAC_ACC: state_d = (r_q == 2'd3) ? ST_COL_END : ST_MAC_RD;
			ST_COL_END: begin
				if (c_q == 2'd3 && mat_q == MAT_W'(NUM_MATRICES - 1)) begin
					state_d = ST_CLIP;
				end else begin
					state_d = ST_MAC_RD;
				end
			end
			ST_CLIP:    state_d = vis_now ? ST_SX_MUL : ST_OUT;
			ST_SX_MUL:  state_d = ST_SX_DIVS;
			ST_SX_DIVS: state_d = ST_SX_DIVW;
			ST_SX_DIVW: if (div_done) state_d = ST_SY_MUL;
			ST_SY_MUL:  state_d = ST_SY_DIVS;
			ST_SY_DIVS: state_d = ST_SY_DIVW;
			ST_SY_DIVW: if (div_done) state_d = ST_T_DIVS;
			ST_T_DIVS:  state_d = ST_T_DIVW;
			ST_T_DIVW:  if (div_done) state_d = ST_DEP_MUL;
			ST_DEP_MUL: state_d = ST_DEP_ADD;
			ST_DEP_ADD: state_d = ST_OUT;
			ST_OUT:     if (!out_valid_q || rsp.ready) state_d = ST_IDLE;
			default:    state_d = ST_IDLE;
		endcase
	end

	// Sequencer outputs.
	always_comb begin
		req.ready = (state_q == ST_IDLE);
		div_start = (state_q == ST_SX_DIVS) || (state_q == ST_SY_DIVS)
			|| (state_q == ST_T_DIVS);
		out_load  = (state_q == ST_OUT) && (!out_valid_q || rsp.ready);
	end

	// Control registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			r_q         <= '0;
			c_q         <= '0;
			mat_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (rsp.ready) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					r_q   <= '0;
					c_q   <= '0;
					mat_q <= mat_first;
				end
				ST_MAC_ACC: r_q <= r_q + 2'd1;
				ST_COL_END: begin
					c_q <= c_q + 2'd1;
					if (c_q == 2'd3) begin
						mat_q <= mat_q + MAT_W'(1);
					end
				end
				default: ;
			endcase
		end
	end

	// Coefficient store: loads from idle, reads under the sequencer.
	always_ff @(posedge clk) begin
		if (req_take && req.cmd == CMD_LOAD && req.coef_index < COEF_IDX_W'(STORE_DEPTH)) begin
			coef_mem[req.coef_index[ADDR_W-1:0]] <= req.coef_value;
		end
		rd_q <= coef_mem[rd_addr];
	end

	// Datapath registers.
	always_ff @(posedge clk) begin
		prod_q <= mul_p;
		case (state_q)
			ST_IDLE: begin
				acc_q  <= '0;
				v_q[0] <= sat32(in_x);
				v_q[1] <= sat32(in_y);
				v_q[2] <= req.point_z;
				v_q[3] <= WORD_W'(1) <<< FRAC_BITS;
			end
			ST_MAC_ACC: acc_q <= acc_q + (prod_q >>> FRAC_BITS);
			ST_COL_END: begin
				acc_q     <= '0;
				o_q[c_q]  <= sat32(acc_q);
				if (c_q == 2'd3) begin
					v_q[0] <= o_q[0];
					v_q[1] <= o_q[1];
					v_q[2] <= o_q[2];
					v_q[3] <= sat32(acc_q);
				end
			end
			ST_CLIP: begin
				vis_q <= vis_now;
				sx_q  <= '0;
				sy_q  <= '0;
				dep_q <= '0;
			end
			ST_SX_DIVW: if (div_done) sx_q <= sat16(scr_sum);
			ST_SY_DIVW: if (div_done) sy_q <= sat16(scr_sum);
			ST_T_DIVW:  if (div_done) t_q <= div_quot[FRAC_BITS:0];
			ST_DEP_ADD: dep_q <= sat32(WIDE_W'(near_q) + (prod_q >>> FRAC_BITS));
			default: ;
		endcase
	end

	// Output register.
	always_ff @(posedge clk) begin
		if (out_load) begin
			rsp.visible  <= vis_q;
			rsp.screen_x <= sx_q;
			rsp.screen_y <= sy_q;
			rsp.depth    <= dep_q;
		end
	end

	assign rsp.valid = out_valid_q;

	// The divider is never restarted while it still works.
	assert property (@(posedge clk) disable iff (!arst_n) div_start |-> !div_busy)
		else $error("divider started while busy");

	// A result that is loaded is shown in the next cycle.
	assert property (@(posedge clk) disable iff (!arst_n) out_load |=> rsp.valid)
		else $error("loaded result not shown");

	// A clipped point reports zero fields.
	assert property (@(posedge clk) disable iff (!arst_n)
		(rsp.valid && !rsp.visible) |-> (rsp.screen_x == '0 && rsp.screen_y == '0
		&& rsp.depth == '0))
		else $error("clipped point with nonzero fields");

	// Only idle takes new words.
	assert property (@(posedge clk) disable iff (!arst_n)
		(state_q != ST_IDLE) |-> !req.ready)
		else $error("word taken while busy");

	// A point that passes the clip test always has a positive w.
	assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_CLIP && vis_now) |-> !o_q[3][WORD_W-1])
		else $error("visible point with negative w");

endmodule

`default_nettype wire

### rtl/vtcv_div.sv
// Iterative unsigned restoring divider, one quotient bit per cycle.
// Depends on vtcv_pkg for default widths.
`default_nettype none

module vtcv_div import vtcv_pkg::*; #(
	parameter int NUM_W = DIV_NUM_W_DEF,
	parameter int DEN_W = DIV_DEN_W
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             start,
	input  wire logic [NUM_W-1:0] num,
	input  wire logic [DEN_W-1:0] den,
	output logic                  busy,
	output logic                  done,
	output logic [NUM_W-1:0]      quot
);

	localparam int CNT_W = $clog2(NUM_W + 1);

	logic [DEN_W-1:0] rem_q;
	logic [NUM_W-1:0] quo_q;
	logic [DEN_W-1:0] den_q;
	logic [CNT_W-1:0] cnt_q;
	logic             busy_q;
	logic             done_q;
	logic [DEN_W:0]   trial;
	logic             ge;
	logic [DEN_W:0]   diff;

	// Trial subtraction of the divisor from the shifted remainder.
	always_comb begin
		trial = {rem_q, quo_q[NUM_W-1]};
		ge    = trial >= {1'b0, den_q};
		diff  = trial - {1'b0, den_q};
	end

	// Control: busy while bits remain, a one-cycle done at the end.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= CNT_W'(NUM_W);
			end else if (busy_q) begin
				cnt_q <= cnt_q - CNT_W'(1);
				if (cnt_q == CNT_W'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// Remainder and quotient shift registers.
	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			quo_q <= num;
			den_q <= den;
		end else if (busy_q) begin
			rem_q <= ge ? diff[DEN_W-1:0] : trial[DEN_W-1:0];
			quo_q <= {quo_q[NUM_W-2:0], ge};
		end
	end

	assign busy = busy_q;
	assign done = done_q;
	assign quot = quo_q;

endmodule

`default_nettype wire
